FILE: hdl/bls_pkg.sv
`timescale 1ns / 1ps

package bls_pkg;

	localparam int MAX_DEPTH  = 64;
	localparam int DATA_WIDTH = 32;

	localparam int CNT_W    = $clog2(MAX_DEPTH + 1);
	localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
	localparam int GRP_SIZE = 8;
	localparam int GROUPS   = (MAX_DEPTH + GRP_SIZE - 1) / GRP_SIZE;

	localparam logic [6:0] CAP_RESET = 7'd64;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_TOP  = 2'd3
	} bls_op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BADPOS   = 2'd3
	} bls_status_t;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		logic             shift_dn;
		logic             shift_up;
		logic             load;
		logic             peek_en;
		logic [CMP_W-1:0] peek_idx;
		word_t            push_word;
	} bls_row_ctl_t;

	function automatic word_t to_word(input logic [31:0] v);
		logic [63:0] ext;
		ext = {{32{v[31]}}, v};
		return ext[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] to_out(input word_t w);
		logic [63:0] z;
		z = 64'(w);
		return z[31:0];
	endfunction

endpackage

FILE: hdl/bls_op_if.sv
`timescale 1ns / 1ps

interface bls_op_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] push_value;
	logic [6:0]         peek_position;

	modport source (output valid, operation, push_value, peek_position, input ready);
	modport sink (input valid, operation, push_value, peek_position, output ready);
endinterface

FILE: hdl/bls_res_if.sv
`timescale 1ns / 1ps

interface bls_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_data;
	logic [1:0]         status;
	logic               is_empty;
	logic               is_full;
	logic [6:0]         entry_count;

	modport source (output valid, read_data, status, is_empty, is_full, entry_count,
		input ready);
	modport sink (input valid, read_data, status, is_empty, is_full, entry_count,
		output ready);
endinterface

FILE: hdl/bls_cell.sv
`timescale 1ns / 1ps

module bls_cell (
	input  logic          clk,
	input  logic          shift_dn,
	input  logic          shift_up,
	input  logic          sel,
	input  bls_pkg::word_t from_above,
	input  bls_pkg::word_t from_below,
	output bls_pkg::word_t data,
	output bls_pkg::word_t pick
);
	import bls_pkg::*;

	word_t data_q;

	always_ff @(posedge clk) begin
		if (shift_dn) begin
			data_q <= from_above;
		end else if (shift_up) begin
			data_q <= from_below;
		end
	end

	assign data = data_q;
	assign pick = data_q & {DATA_WIDTH{sel}};
endmodule

FILE: hdl/bls_cell_row.sv
`timescale 1ns / 1ps

module bls_cell_row (
	input  logic                                          clk,
	input  bls_pkg::bls_row_ctl_t                         ctl,
	output bls_pkg::word_t                                top_word,
	output logic [bls_pkg::GROUPS-1:0][bls_pkg::DATA_WIDTH-1:0] grp_s1
);
	import bls_pkg::*;

	logic [MAX_DEPTH-1:0][DATA_WIDTH-1:0] cell_data;
	logic [MAX_DEPTH-1:0][DATA_WIDTH-1:0] cell_pick;
	logic [GROUPS-1:0][DATA_WIDTH-1:0]    grp_or;

	for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
		word_t above;
		word_t below;
		logic  sel;

		if (i == 0) begin : g_first
			assign above = ctl.push_word;
		end else begin : g_mid
			assign above = cell_data[i-1];
		end

		if (i == MAX_DEPTH - 1) begin : g_last
			assign below = cell_data[i];
		end else begin : g_inner
			assign below = cell_data[i+1];
		end

		assign sel = ctl.peek_en && (ctl.peek_idx == CMP_W'(i));

		bls_cell u_cell (
			.clk        (clk),
			.shift_dn   (ctl.shift_dn),
			.shift_up   (ctl.shift_up),
			.sel        (sel),
			.from_above (above),
			.from_below (below),
			.data       (cell_data[i]),
			.pick       (cell_pick[i])
		);
	end

	// first level of the peek tree, eight cells per group
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < MAX_DEPTH) begin
					grp_or[g] = grp_or[g] | cell_pick[g * GRP_SIZE + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			grp_s1 <= grp_or;
		end
	end

	assign top_word = cell_data[0];
endmodule

FILE: hdl/bounded_lifo_stack_top.sv
`timescale 1ns / 1ps
// Bounded LIFO stack of signed words held in a row of shifting cells.
// op (sink): one operation per word (push, pop, peek at position, read top).
// res (source): one result word per operation, carrying read data, status,
//   empty and full flags and the entry count after the operation.
// cfg_we/cfg_wdata: capacity register, to be written only while the block is idle
//   (the block itself does not enforce this); zero acts as one, values above the depth saturate at the depth.
// Pipeline: an accepted operation passes through these stages to its result:
//   one stage for the cell update and the first level of the peek tree, one
//   for the final OR of the tree into the output register.
// Throughput: one operation per cycle unless the receiver stalls; each successful push or pop
//   shifts every cell by one place in the same cycle, so the next operation sees the new top.
// Reset clears the entry count, the pipeline valids and sets the capacity to
//   64; cell contents are left as they are and never read before a push.
// When the receiver stalls, the output register holds its word and the
//   middle stage holds one more; op.ready then drops until res drains.
module bounded_lifo_stack_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	bls_op_if.sink     op,
	bls_res_if.source  res
);
	import bls_pkg::*;

	logic [6:0]       cap_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] pos_ext;

	bls_op_t      opc;
	bls_row_ctl_t ctl;
	word_t        top_word;
	logic [GROUPS-1:0][DATA_WIDTH-1:0] grp_s1;

	logic        accept;
	logic        out_free;
	logic        s1_adv;
	logic [CNT_W-1:0] nxt_cnt;
	bls_status_t nxt_status;
	word_t       nxt_data;
	logic        nxt_tree;

	logic             valid_s1;
	bls_status_t      status_s1;
	word_t            data_s1;
	logic             tree_s1;
	logic             empty_s1;
	logic             full_s1;
	logic [CNT_W-1:0] cnt_s1;

	logic        res_valid_q;
	logic [31:0] data_q;
	bls_status_t status_q;
	logic        empty_q;
	logic        full_q;
	logic [6:0]  count_q;
	word_t       tree_word;

	assign out_free = !res_valid_q || res.ready;
	assign s1_adv   = valid_s1 && out_free;
	assign op.ready = !valid_s1 || out_free;
	assign accept   = op.valid && op.ready;

	assign opc     = bls_op_t'(op.operation);
	assign cnt_ext = CMP_W'(cnt_q);
	assign pos_ext = CMP_W'(op.peek_position);

	always_comb begin
		if (cap_q == 7'd0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_DEPTH)) begin
			cap_eff = CMP_W'(MAX_DEPTH);
		end else begin
			cap_eff = CMP_W'(cap_q);
		end
	end

	always_comb begin
		nxt_cnt      = cnt_q;
		nxt_status   = ST_OK;
		nxt_data     = '1;
		nxt_tree     = 1'b0;
		ctl.shift_dn = 1'b0;
		ctl.shift_up = 1'b0;
		ctl.load     = accept;
		ctl.peek_en  = 1'b0;
		ctl.peek_idx = pos_ext - CMP_W'(1);
		ctl.push_word = to_word(op.push_value);
		case (opc)
			OP_PUSH: begin
				if (cnt_ext >= cap_eff) begin
					nxt_status = ST_OVERFLOW;
				end else begin
					ctl.shift_dn = accept;
					nxt_cnt      = cnt_q + CNT_W'(1);
					nxt_data     = '0;
				end
			end
			OP_POP: begin
				if (cnt_q == '0) begin
					nxt_status = ST_EMPTY;
				end else begin
					ctl.shift_up = accept;
					nxt_cnt      = cnt_q - CNT_W'(1);
					nxt_data     = top_word;
				end
			end
			OP_PEEK: begin
				if (pos_ext == '0 || pos_ext > cnt_ext) begin
					nxt_status = ST_BADPOS;
				end else begin
					ctl.peek_en = 1'b1;
					nxt_tree    = 1'b1;
				end
			end
			OP_TOP: begin
				if (cnt_q == '0) begin
					nxt_status = ST_EMPTY;
				end else begin
					nxt_data = top_word;
				end
			end
			default: begin
				nxt_status = ST_OK;
			end
		endcase
	end

	bls_cell_row u_row (
		.clk      (clk),
		.ctl      (ctl),
		.top_word (top_word),
		.grp_s1   (grp_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q    <= nxt_cnt;
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= nxt_status;
			data_s1   <= nxt_data;
			tree_s1   <= nxt_tree;
			cnt_s1    <= nxt_cnt;
			empty_s1  <= (nxt_cnt == '0);
			full_s1   <= (CMP_W'(nxt_cnt) >= cap_eff);
		end
	end

	always_comb begin
		tree_word = '0;
		for (int g = 0; g < GROUPS; g++) begin
			tree_word = tree_word | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			data_q   <= to_out(tree_s1 ? tree_word : data_s1);
			status_q <= status_s1;
			empty_q  <= empty_s1;
			full_q   <= full_s1;
			count_q  <= 7'(cnt_s1);
		end
	end

	assign res.valid       = res_valid_q;
	assign res.read_data   = data_q;
	assign res.status      = status_q;
	assign res.is_empty    = empty_q;
	assign res.is_full     = full_q;
	assign res.entry_count = count_q;
endmodule

FILE: hdl/bls_checker.sv
`timescale 1ns / 1ps

module bls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] read_data,
	input logic [1:0]  status,
	input logic        is_empty,
	input logic        is_full,
	input logic [6:0]  entry_count
);
	import bls_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (is_empty == (entry_count == 7'd0)))
		else $error("empty flag disagrees with count");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_OVERFLOW |-> is_full)
		else $error("overflow reported while not full");

	a_error_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_OK |-> (DATA_WIDTH < 32) || (read_data == 32'hFFFF_FFFF))
		else $error("error result without all-ones data");

	a_empty_not_underflow_push: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> is_empty)
		else $error("empty status on a non-empty stack");
endmodule

bind bounded_lifo_stack_top bls_checker u_bls_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.read_data   (res.read_data),
	.status      (res.status),
	.is_empty    (res.is_empty),
	.is_full     (res.is_full),
	.entry_count (res.entry_count)
);

FILE: test/tb_stack_checker.sv
`timescale 1ns / 1ps

module tb_stack_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	bls_op_if          op,
	bls_res_if         res,
	input  logic       end_check,
	output int         fail_count,
	output int         pending
);
	import bls_pkg::*;

	typedef struct packed {
		logic [31:0] data;
		bls_status_t status;
		logic        empty;
		logic        full;
		logic [6:0]  count;
	} stack_word_t;

	word_t       cells [MAX_DEPTH];
	int unsigned depth_used;
	logic [6:0]  capacity;
	stack_word_t awaited [$];

	function automatic int unsigned usable_depth();
		if (capacity == 7'd0) begin
			return 1;
		end
		if (capacity > MAX_DEPTH) begin
			return MAX_DEPTH;
		end
		return capacity;
	endfunction

	function automatic stack_word_t apply_op(input bls_op_t o, input logic [31:0] v,
		input logic [6:0] p);
		stack_word_t r;
		int unsigned lim;
		lim = usable_depth();
		r.data = '1;
		r.status = ST_OK;
		case (o)
			OP_PUSH: begin
				if (depth_used >= lim) begin
					r.status = ST_OVERFLOW;
				end else begin
					cells[depth_used] = word_t'($signed(v));
					depth_used++;
					r.data = '0;
				end
			end
			OP_POP: begin
				if (depth_used == 0) begin
					r.status = ST_EMPTY;
				end else begin
					depth_used--;
					r.data = 32'(cells[depth_used]);
				end
			end
			OP_PEEK: begin
				if (p == 7'd0 || p > depth_used) begin
					r.status = ST_BADPOS;
				end else begin
					r.data = 32'(cells[depth_used - p]);
				end
			end
			default: begin
				if (depth_used == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.data = 32'(cells[depth_used - 1]);
				end
			end
		endcase
		r.empty = (depth_used == 0);
		r.full = (depth_used >= lim);
		r.count = 7'(depth_used);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] stack mismatch: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		stack_word_t want;
		if (!arst_n) begin
			depth_used = 0;
			capacity = CAP_RESET;
			awaited.delete();
			fail_count = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (awaited.size() == 0) begin
					report_mismatch("result word with no operation waiting", res.read_data, '0);
				end else begin
					want = awaited.pop_front();
					if (res.read_data !== want.data)
						report_mismatch("read_data", res.read_data, want.data);
					if (res.status !== want.status)
						report_mismatch("status", 32'(res.status), 32'(want.status));
					if (res.is_empty !== want.empty)
						report_mismatch("is_empty", 32'(res.is_empty), 32'(want.empty));
					if (res.is_full !== want.full)
						report_mismatch("is_full", 32'(res.is_full), 32'(want.full));
					if (res.entry_count !== want.count)
						report_mismatch("entry_count", 32'(res.entry_count), 32'(want.count));
				end
			end
			if (op.valid && op.ready) begin
				awaited.push_back(apply_op(bls_op_t'(op.operation), op.push_value,
					op.peek_position));
			end
			if (cfg_we) begin
				capacity = cfg_wdata;
			end
		end
		pending = awaited.size();
	end

	always @(posedge end_check) begin
		if (awaited.size() != 0) begin
			report_mismatch("result words never delivered", 32'(awaited.size()), '0);
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bls_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	logic       end_check;
	logic       idle_en;
	int         fail_count;
	int         pending;
	int         stall_cycles;

	bls_op_if  op_if ();
	bls_res_if res_if ();

	bounded_lifo_stack_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.op        (op_if),
		.res       (res_if)
	);

	tb_stack_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.op         (op_if),
		.res        (res_if),
		.end_check  (end_check),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		res_if.ready <= !idle_en || ($urandom_range(0, 99) >= 35);
	end

	always @(posedge clk) begin
		if (!arst_n || (op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_op(input bls_op_t o, input logic [31:0] v, input logic [6:0] p);
		while (idle_en && $urandom_range(0, 99) < 35) begin
			op_if.valid <= 1'b0;
			@(negedge clk);
		end
		op_if.valid <= 1'b1;
		op_if.operation <= o;
		op_if.push_value <= v;
		op_if.peek_position <= p;
		do @(posedge clk); while (!(op_if.valid && op_if.ready));
		@(negedge clk);
	endtask

	task automatic drain();
		op_if.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [6:0] cap);
		drain();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_ops(input int n, input int push_pct, input int pop_pct);
		int          r;
		logic [31:0] v;
		logic [6:0]  p;
		bls_op_t     o;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				2: v = 32'hffff_ffff;
				3: v = 32'h0;
				default: v = $urandom;
			endcase
			p = $urandom_range(0, 1) ? 7'($urandom_range(0, 10)) : 7'($urandom_range(0, 64));
			if (r < push_pct) begin
				o = OP_PUSH;
			end else if (r < push_pct + pop_pct) begin
				o = OP_POP;
			end else if ($urandom_range(0, 2) != 0) begin
				o = OP_PEEK;
			end else begin
				o = OP_TOP;
			end
			send_op(o, v, p);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = CAP_RESET;
		end_check = 1'b0;
		idle_en = 1'b1;
		op_if.valid = 1'b0;
		op_if.operation = OP_PUSH;
		op_if.push_value = '0;
		op_if.peek_position = '0;
		res_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty stack, word extremes, peek bounds
		send_op(OP_POP, 32'h1234_5678, 7'd0);
		send_op(OP_TOP, 32'h0, 7'd0);
		send_op(OP_PEEK, 32'h0, 7'd0);
		send_op(OP_PEEK, 32'h0, 7'd1);
		send_op(OP_PUSH, 32'h7fff_ffff, 7'd0);
		send_op(OP_PUSH, 32'h8000_0000, 7'd0);
		send_op(OP_PUSH, 32'hffff_ffff, 7'd0);
		send_op(OP_PUSH, 32'h0, 7'd0);
		send_op(OP_TOP, 32'h0, 7'd0);
		send_op(OP_PEEK, 32'h0, 7'd1);
		send_op(OP_PEEK, 32'h0, 7'd4);
		send_op(OP_PEEK, 32'h0, 7'd5);
		send_op(OP_PEEK, 32'h0, 7'd0);
		send_op(OP_PEEK, 32'h0, 7'd64);
		repeat (5) send_op(OP_POP, 32'h0, 7'd0);

		// smallest capacity, and zero acting as one
		set_capacity(7'd1);
		send_op(OP_PUSH, 32'h5a5a_a5a5, 7'd0);
		send_op(OP_PUSH, 32'ha5a5_5a5a, 7'd0);
		send_op(OP_TOP, 32'h0, 7'd0);
		set_capacity(7'd0);
		send_op(OP_PEEK, 32'h0, 7'd1);
		send_op(OP_PUSH, 32'h0bad_f00d, 7'd0);
		send_op(OP_POP, 32'h0, 7'd0);

		set_capacity(7'd127);
		random_ops(200, 60, 15);
		set_capacity(7'd64);
		random_ops(150, 25, 50);
		idle_en <= 1'b0;
		random_ops(200, 45, 35);
		idle_en <= 1'b1;
		set_capacity(7'd2);
		random_ops(150, 40, 30);
		set_capacity(7'd0);
		random_ops(100, 40, 30);
		set_capacity(7'd64);
		random_ops(120, 80, 5);
		drain();
		// capacity lowered under the words held
		set_capacity(7'd5);
		random_ops(150, 30, 50);
		set_capacity(7'd100);
		random_ops(150, 55, 25);
		repeat (6) begin
			set_capacity(7'($urandom_range(1, 64)));
			random_ops(100, 50, 30);
		end

		drain();
		repeat (10) @(negedge clk);
		end_check <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
